FILE: design/sme_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; used by every module of the block.
package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int PUSH_BOUND  = 9999;

    typedef logic [WORD_W-1:0] word_t;

    // instruction opcodes
    typedef enum logic [2:0] {
        OP_PUSH  = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_PRINT = 3'd4,
        OP_HALT  = 3'd5
    } opcode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PRINTED   = 3'd1,
        ST_HALTED    = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_INVALID   = 3'd5,
        ST_IGNORED   = 3'd6
    } status_t;

    // per-cell move: hold, take from the neighbor above (toward top), take from below
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_TAKE_UP   = 2'd1,
        CELL_TAKE_DOWN = 2'd2
    } cell_cmd_t;

    // stack-wide operation issued by the controller
    typedef enum logic [1:0] {
        STK_HOLD  = 2'd0,
        STK_PUSH  = 2'd1,
        STK_POP   = 2'd2,
        STK_MERGE = 2'd3
    } stack_op_t;

    typedef struct packed {
        stack_op_t op;
        word_t     din;
    } stack_ctl_t;

endpackage

FILE: design/sme_cell.sv
// One entry of the operand stack: a word register fed by its two neighbors.
// Depends on sme_pkg.
module sme_cell (
    input  logic               clk,
    input  sme_pkg::cell_cmd_t cmd,
    input  sme_pkg::word_t     up_data,
    input  sme_pkg::word_t     down_data,
    output sme_pkg::word_t     q
);

    sme_pkg::word_t q_reg;
    sme_pkg::word_t q_next;

    always_comb
    begin
        case (cmd)
            sme_pkg::CELL_TAKE_UP:   q_next = up_data;
            sme_pkg::CELL_TAKE_DOWN: q_next = down_data;
            default:                 q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: design/sme_stack.sv
// Operand stack as a row of shifting cells; cell 0 is the top of stack.
// Depends on sme_pkg and sme_cell.
module sme_stack (
    input  logic                clk,
    input  sme_pkg::stack_ctl_t ctl,
    output sme_pkg::word_t      top0,
    output sme_pkg::word_t      top1
);

    sme_pkg::word_t q [sme_pkg::STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < sme_pkg::STACK_DEPTH; i++)
        begin : g_cell
            sme_pkg::cell_cmd_t cmd;
            sme_pkg::word_t     up_data;
            sme_pkg::word_t     down_data;

            if (i == 0)
            begin : g_top
                assign up_data = ctl.din;
            end
            else
            begin : g_mid
                assign up_data = q[i-1];
            end

            if (i == sme_pkg::STACK_DEPTH - 1)
            begin : g_bot
                assign down_data = '0;
            end
            else
            begin : g_inner
                assign down_data = q[i+1];
            end

            // merge: top takes the sum or difference, the rest close the gap left by the popped entry
            always_comb
            begin
                case (ctl.op)
                    sme_pkg::STK_PUSH:  cmd = sme_pkg::CELL_TAKE_UP;
                    sme_pkg::STK_POP:   cmd = sme_pkg::CELL_TAKE_DOWN;
                    sme_pkg::STK_MERGE: cmd = (i == 0) ? sme_pkg::CELL_TAKE_UP
                                                       : sme_pkg::CELL_TAKE_DOWN;
                    default:            cmd = sme_pkg::CELL_HOLD;
                endcase
            end

            sme_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .up_data   (up_data),
                .down_data (down_data),
                .q         (q[i])
            );
        end
    endgenerate

    assign top0 = q[0];
    assign top1 = q[1];

endmodule

FILE: design/stack_machine_executor_top.sv
// Stack machine executor: decodes one instruction per request and drives the cell stack.
// Depends on sme_pkg and sme_stack.
//
//  channel   | dir | tdata fields (low bit up)                          | tuser
//  s_axis    | in  | operation[2:0], push_value[17:3], pad to 24        | -
//  m_axis    | out | status[2:0], printed_value[34:3], stack_depth[41:35], pad to 48 | -
//
// One instruction per cycle while the output is not stalled: the whole stack shifts
// at once, and only the top two cells feed the adder.
// The result sits in one output register; a new request is taken when it is empty
// or is taken downstream in the same cycle, so a stalled m side stalls s after one item.
// Reset clears depth, stop flag and output valid; stack contents stay undefined.
module stack_machine_executor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[2:0], push_value[17:3], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], printed_value[34:3], stack_depth[41:35], zeros
);

    localparam logic [sme_pkg::DEPTH_W-1:0] FULL =
        sme_pkg::DEPTH_W'(sme_pkg::STACK_DEPTH);
    localparam logic signed [14:0] BOUND_POS = 15'(sme_pkg::PUSH_BOUND);
    localparam logic signed [14:0] BOUND_NEG = -15'(sme_pkg::PUSH_BOUND);

    logic [2:0]         operation;
    logic signed [14:0] push_value;
    logic signed [14:0] push_sat;
    logic               accept;

    logic [sme_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic                        stopped_reg, stopped_next;
    logic                        out_valid_reg, out_valid_next;
    sme_pkg::status_t            out_status_reg, out_status_next;
    sme_pkg::word_t              out_value_reg, out_value_next;
    logic [sme_pkg::DEPTH_W-1:0] out_depth_reg;

    sme_pkg::stack_ctl_t ctl;
    sme_pkg::word_t      top0, top1;

    assign operation  = s_tdata[2:0];
    assign push_value = s_tdata[17:3];
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        if (push_value > BOUND_POS)
            push_sat = BOUND_POS;
        else if (push_value < BOUND_NEG)
            push_sat = BOUND_NEG;
        else
            push_sat = push_value;
    end

    always_comb
    begin
        depth_next      = depth_reg;
        stopped_next    = stopped_reg;
        out_status_next = sme_pkg::ST_OK;
        out_value_next  = '0;
        ctl.op          = sme_pkg::STK_HOLD;
        ctl.din         = {{(sme_pkg::WORD_W-15){push_sat[14]}}, push_sat};

        if (stopped_reg)
        begin
            out_status_next = sme_pkg::ST_IGNORED;
        end
        else
        begin
            case (operation)
                sme_pkg::OP_PUSH:
                begin
                    if (depth_reg >= FULL)
                    begin
                        stopped_next    = 1'b1;
                        out_status_next = sme_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        ctl.op     = sme_pkg::STK_PUSH;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB:
                begin
                    if (depth_reg < sme_pkg::DEPTH_W'(2))
                    begin
                        stopped_next    = 1'b1;
                        out_status_next = sme_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        // top1 is a, top0 is b
                        ctl.op     = sme_pkg::STK_MERGE;
                        ctl.din    = (operation == sme_pkg::OP_ADD) ? top1 + top0
                                                                    : top1 - top0;
                        depth_next = depth_reg - 1'b1;
                    end
                end
                sme_pkg::OP_PRINT:
                begin
                    if (depth_reg == '0)
                    begin
                        stopped_next    = 1'b1;
                        out_status_next = sme_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.op          = sme_pkg::STK_POP;
                        depth_next      = depth_reg - 1'b1;
                        out_status_next = sme_pkg::ST_PRINTED;
                        out_value_next  = top0;
                    end
                end
                sme_pkg::OP_HALT:
                begin
                    stopped_next    = 1'b1;
                    out_status_next = sme_pkg::ST_HALTED;
                end
                default:
                begin
                    stopped_next    = 1'b1;
                    out_status_next = sme_pkg::ST_INVALID;
                end
            endcase
        end

        // drop everything unless a request is taken this cycle
        if (!accept)
        begin
            ctl.op       = sme_pkg::STK_HOLD;
            depth_next   = depth_reg;
            stopped_next = stopped_reg;
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    sme_stack u_stack (
        .clk  (clk),
        .ctl  (ctl),
        .top0 (top0),
        .top1 (top1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_depth_reg  <= depth_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_depth_reg, out_value_reg, out_status_reg};

endmodule
